[rtl/core/histmmm_pkg.sv]
// Shared types and constants for the histogram mean, median and mode block.
package histmmm_pkg;

    localparam int MAX_ITEMS_DEF = 128;
    localparam int NUM_BINS_DEF  = 10;

    localparam int VALUE_W = 4;
    localparam int COUNT_W = 8;
    localparam int TOTAL_W = 11;

    typedef struct packed {
        logic [VALUE_W-1:0] response_value;
        logic               last_item;
    } hist_item_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] sum_total;
        logic [COUNT_W-1:0] item_count;
        logic [VALUE_W-1:0] median_value;
        logic [VALUE_W-1:0] mode_value;
        logic [COUNT_W-1:0] mode_count;
        logic [VALUE_W-1:0] second_mode;
        logic               two_modes;
        logic               overflow;
    } hist_result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } hist_state_t;

endpackage

[rtl/core/histogram_mean_median_mode.sv]
// Top level of the histogram mean, median and mode block.
//
// Usage:
// The item channel (item_valid, item_ready, item) carries one response value per
// transaction together with a last-item mark. Values are counted in a histogram held
// in a synchronous memory of NUM_BINS entries; one value is taken every cycle in the
// run state. The result channel (result_valid, result_ready, result) carries one
// transaction per batch, issued after the one that carries the last-item mark.
// After the last item the block scans the histogram once, one bin per cycle through
// the single memory read port, and clears each bin behind the scan. The result is
// loaded into the output register in the done state that follows the scan and flush
// states, and the item channel stays closed until that load. After reset the block
// sweeps every memory bin to zero before it raises item_ready. A stalled result
// waits in the output register while the next batch is taken; only the end of that
// batch waits for the register to be free. Values of NUM_BINS or more are ignored,
// and values beyond MAX_ITEMS are dropped and reported through the overflow field.
module histogram_mean_median_mode #(
    parameter int MAX_ITEMS = histmmm_pkg::MAX_ITEMS_DEF,
    parameter int NUM_BINS  = histmmm_pkg::NUM_BINS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  histmmm_pkg::hist_item_t   item,
    output logic                     result_valid,
    input  logic                     result_ready,
    output histmmm_pkg::hist_result_t result
);

    localparam int BIN_AW  = $clog2(NUM_BINS);
    localparam int COUNT_W = histmmm_pkg::COUNT_W;
    localparam int TOTAL_W = histmmm_pkg::TOTAL_W;
    localparam int VALUE_W = histmmm_pkg::VALUE_W;
    localparam logic [BIN_AW-1:0]  LAST_BIN  = BIN_AW'(NUM_BINS - 1);
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_ITEMS);

    histmmm_pkg::hist_state_t state_reg, state_next;
    logic [BIN_AW-1:0]  idx_reg, idx_next;

    logic [COUNT_W-1:0] bin_mem [NUM_BINS];
    logic [COUNT_W-1:0] rdata_reg;

    logic               rd_en;
    logic [BIN_AW-1:0]  rd_addr;
    logic               rd_scan;
    logic               rd_end;

    logic               st_vld_reg;
    logic [BIN_AW-1:0]  st_addr_reg;
    logic               st_scan_reg;
    logic               st_end_reg;

    logic               wr_en;
    logic [BIN_AW-1:0]  wr_addr;
    logic [COUNT_W-1:0] wr_data;

    logic               lw_vld_reg;
    logic [BIN_AW-1:0]  lw_addr_reg;
    logic [COUNT_W-1:0] lw_data_reg;

    logic [COUNT_W-1:0] cur_count;

    logic [COUNT_W-1:0] count_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               drop_reg;

    logic [COUNT_W-1:0] cum_reg;
    logic               lo_found_reg;
    logic               hi_found_reg;
    logic [BIN_AW-1:0]  lo_val_reg;
    logic [BIN_AW-1:0]  hi_val_reg;
    logic [COUNT_W-1:0] largest_reg;
    logic [BIN_AW-1:0]  mode_reg;
    logic [BIN_AW-1:0]  second_reg;
    logic [COUNT_W-1:0] cnt_mode_reg;
    logic [COUNT_W-1:0] cnt_second_reg;

    logic               res_vld_reg;
    histmmm_pkg::hist_result_t res_reg;

    logic               item_acc;
    logic               in_range;
    logic               take_value;
    logic               res_load;
    logic               scan_proc;
    logic [COUNT_W-1:0] lo_pos;
    logic [COUNT_W-1:0] hi_pos;
    logic [COUNT_W-1:0] cum_base;
    logic [COUNT_W-1:0] cum_new;
    logic               lo_hit;
    logic               hi_hit;
    logic [TOTAL_W:0]   total_sum;
    logic [BIN_AW:0]    median_sum;

    assign item_acc   = item_valid && item_ready;
    assign in_range   = {1'b0, item.response_value} < (VALUE_W + 1)'(NUM_BINS);
    assign take_value = item_acc && in_range && (count_reg < MAX_COUNT);
    assign res_load   = (state_reg == histmmm_pkg::ST_DONE) && (!res_vld_reg || result_ready);
    assign scan_proc  = st_vld_reg && st_scan_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        item_ready = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        rd_scan    = 1'b0;
        rd_end     = 1'b0;
        case (state_reg)
            histmmm_pkg::ST_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_BIN)
                begin
                    idx_next   = '0;
                    state_next = histmmm_pkg::ST_RUN;
                end
            end
            histmmm_pkg::ST_RUN:
            begin
                item_ready = 1'b1;
                if (take_value)
                begin
                    rd_en   = 1'b1;
                    rd_addr = item.response_value[BIN_AW-1:0];
                end
                if (item_acc && item.last_item)
                begin
                    idx_next   = '0;
                    state_next = histmmm_pkg::ST_SCAN;
                end
            end
            histmmm_pkg::ST_SCAN:
            begin
                rd_en    = 1'b1;
                rd_addr  = idx_reg;
                rd_scan  = 1'b1;
                rd_end   = (idx_reg == LAST_BIN);
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_BIN)
                begin
                    idx_next   = '0;
                    state_next = histmmm_pkg::ST_FLUSH;
                end
            end
            histmmm_pkg::ST_FLUSH:
            begin
                if (scan_proc && st_end_reg)
                begin
                    state_next = histmmm_pkg::ST_DONE;
                end
            end
            histmmm_pkg::ST_DONE:
            begin
                if (res_load)
                begin
                    state_next = histmmm_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = histmmm_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= histmmm_pkg::ST_CLEAR;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign cur_count = (lw_vld_reg && (lw_addr_reg == st_addr_reg)) ? lw_data_reg : rdata_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = st_addr_reg;
        wr_data = '0;
        if (state_reg == histmmm_pkg::ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = idx_reg;
        end
        else if (st_vld_reg)
        begin
            wr_en   = 1'b1;
            wr_data = st_scan_reg ? '0 : cur_count + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= bin_mem[rd_addr];
        end
        if (wr_en)
        begin
            bin_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_vld_reg <= 1'b0;
            lw_vld_reg <= 1'b0;
        end
        else
        begin
            st_vld_reg <= rd_en;
            lw_vld_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        st_addr_reg <= rd_addr;
        st_scan_reg <= rd_scan;
        st_end_reg  <= rd_end;
        lw_addr_reg <= wr_addr;
        lw_data_reg <= wr_data;
    end

    assign total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(item.response_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else if (res_load)
        begin
            count_reg <= '0;
            total_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else if (take_value)
        begin
            count_reg <= count_reg + 1'b1;
            total_reg <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
        end
        else if (item_acc && in_range)
        begin
            drop_reg <= 1'b1;
        end
    end

    assign hi_pos   = count_reg >> 1;
    assign lo_pos   = (count_reg == '0) ? '0 : (count_reg - 1'b1) >> 1;
    assign cum_base = (st_addr_reg == '0) ? '0 : cum_reg;
    assign cum_new  = cum_base + cur_count;
    assign lo_hit   = ((st_addr_reg == '0) || !lo_found_reg) && (lo_pos < cum_new);
    assign hi_hit   = ((st_addr_reg == '0) || !hi_found_reg) && (hi_pos < cum_new);

    always_ff @(posedge clk)
    begin
        if (scan_proc)
        begin
            cum_reg <= cum_new;
            if (st_addr_reg == '0)
            begin
                lo_found_reg   <= lo_hit;
                hi_found_reg   <= hi_hit;
                lo_val_reg     <= '0;
                hi_val_reg     <= '0;
                largest_reg    <= '0;
                mode_reg       <= '0;
                second_reg     <= '0;
                cnt_mode_reg   <= cur_count;
                cnt_second_reg <= cur_count;
            end
            else
            begin
                if (lo_hit)
                begin
                    lo_found_reg <= 1'b1;
                    lo_val_reg   <= st_addr_reg;
                end
                if (hi_hit)
                begin
                    hi_found_reg <= 1'b1;
                    hi_val_reg   <= st_addr_reg;
                end
                if (cur_count > largest_reg)
                begin
                    largest_reg  <= cur_count;
                    mode_reg     <= st_addr_reg;
                    cnt_mode_reg <= cur_count;
                end
                else if (cur_count == largest_reg)
                begin
                    second_reg     <= st_addr_reg;
                    cnt_second_reg <= cur_count;
                end
            end
        end
    end

    assign median_sum = {1'b0, lo_val_reg} + {1'b0, hi_val_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg.sum_total    <= total_reg;
            res_reg.item_count   <= count_reg;
            res_reg.median_value <= VALUE_W'(median_sum >> 1);
            res_reg.mode_value   <= VALUE_W'(mode_reg);
            res_reg.mode_count   <= largest_reg;
            res_reg.second_mode  <= VALUE_W'(second_reg);
            res_reg.two_modes    <= (cnt_second_reg == cnt_mode_reg);
            res_reg.overflow     <= drop_reg;
        end
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (item_acc && item.last_item) |=> (state_reg == histmmm_pkg::ST_SCAN))
    else $error("scan did not start after the last item");

    assert property (@(posedge clk) disable iff (!rst_n)
        scan_proc |-> (state_reg == histmmm_pkg::ST_SCAN || state_reg == histmmm_pkg::ST_FLUSH))
    else $error("scan read completed outside the scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (count_reg <= MAX_COUNT) && (largest_reg <= count_reg))
    else $error("result counts exceed the batch size");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_vld_reg) |-> (res_reg.median_value < VALUE_W'(NUM_BINS)
            || NUM_BINS == (1 << VALUE_W)))
    else $error("median outside the bin range");

endmodule

[dv/histogram_mean_median_mode_tb.sv]
`timescale 1ns / 1ps
// Testbench for the histogram mean, median and mode block.
module histogram_mean_median_mode_tb;

    localparam int MAX_ITEMS   = histmmm_pkg::MAX_ITEMS_DEF;
    localparam int NUM_BINS    = histmmm_pkg::NUM_BINS_DEF;
    localparam int VALUE_W     = histmmm_pkg::VALUE_W;
    localparam int COUNT_W     = histmmm_pkg::COUNT_W;
    localparam int TOTAL_W     = histmmm_pkg::TOTAL_W;
    localparam int TOTAL_CAP   = (1 << TOTAL_W) - 1;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1400;

    logic                      clk;
    logic                      rst_n;
    logic                      item_valid;
    logic                      item_ready;
    histmmm_pkg::hist_item_t   item;
    logic                      result_valid;
    logic                      result_ready;
    histmmm_pkg::hist_result_t result;

    int unsigned                 hist_bins [NUM_BINS];
    int unsigned                 hist_total;
    int unsigned                 hist_taken;
    bit                          hist_dropped;
    histmmm_pkg::hist_result_t   pending_stats [$];

    int mismatches;
    int burst_left;
    bit gaps_enabled;
    int hold_seq;

    histogram_mean_median_mode DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int unsigned value_at_rank(int unsigned rank);
        int unsigned running;
        running = 0;
        for (int b = 0; b < NUM_BINS; b++)
        begin
            running += hist_bins[b];
            if (rank < running)
                return b;
        end
        return 0;
    endfunction

    function automatic void clear_histogram();
        foreach (hist_bins[b])
            hist_bins[b] = 0;
        hist_total   = 0;
        hist_taken   = 0;
        hist_dropped = 1'b0;
    endfunction

    function automatic histmmm_pkg::hist_result_t summarize_batch();
        histmmm_pkg::hist_result_t r;
        int unsigned  n;
        int unsigned  mid;
        int unsigned  largest;
        int unsigned  mode_v;
        int unsigned  second_v;
        n = hist_taken;
        if (n == 0)
            mid = 0;
        else if (n % 2 == 1)
            mid = value_at_rank(n / 2);
        else
            mid = (value_at_rank(n / 2 - 1) + value_at_rank(n / 2)) / 2;
        largest  = 0;
        mode_v   = 0;
        second_v = 0;
        for (int b = 1; b < NUM_BINS; b++)
        begin
            if (hist_bins[b] > largest)
            begin
                largest = hist_bins[b];
                mode_v  = b;
            end
            else if (hist_bins[b] == largest)
            begin
                second_v = b;
            end
        end
        r.sum_total    = hist_total[TOTAL_W-1:0];
        r.item_count   = n[COUNT_W-1:0];
        r.median_value = mid[VALUE_W-1:0];
        r.mode_value   = mode_v[VALUE_W-1:0];
        r.mode_count   = largest[COUNT_W-1:0];
        r.second_mode  = second_v[VALUE_W-1:0];
        r.two_modes    = (hist_bins[second_v] == hist_bins[mode_v]);
        r.overflow     = hist_dropped;
        return r;
    endfunction

    function automatic void tally_response(histmmm_pkg::hist_item_t it);
        if (it.response_value < NUM_BINS)
        begin
            if (hist_taken < MAX_ITEMS)
            begin
                hist_bins[it.response_value]++;
                hist_taken++;
                hist_total += it.response_value;
                if (hist_total > TOTAL_CAP)
                    hist_total = TOTAL_CAP;
            end
            else
            begin
                hist_dropped = 1'b1;
            end
        end
        if (it.last_item)
        begin
            pending_stats.push_back(summarize_batch());
            clear_histogram();
        end
    endfunction

    task automatic send_item(input int unsigned value, input bit last);
        histmmm_pkg::hist_item_t it;
        int         gap;
        it.response_value = value[VALUE_W-1:0];
        it.last_item      = last;
        if (gaps_enabled && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        tally_response(it);
    endtask

    task automatic send_batch(input int unsigned vals [$]);
        foreach (vals[i])
            send_item(vals[i], i == vals.size() - 1);
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    // Each result transaction is checked against the oldest expected batch summary.
    always @(posedge clk)
    begin
        histmmm_pkg::hist_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_stats.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result expected none actual %p", $time, result);
            end
            else
            begin
                want = pending_stats.pop_front();
                compare_field("sum_total", want.sum_total, result.sum_total);
                compare_field("item_count", want.item_count, result.item_count);
                compare_field("median_value", want.median_value, result.median_value);
                compare_field("mode_value", want.mode_value, result.mode_value);
                compare_field("mode_count", want.mode_count, result.mode_count);
                compare_field("second_mode", want.second_mode, result.second_mode);
                compare_field("two_modes", want.two_modes, result.two_modes);
                compare_field("overflow", want.overflow, result.overflow);
            end
        end
    end

    // The receiver rotates through stall patterns and takes a long hold on request.
    initial
    begin
        int hold_seen;
        int hold_left;
        int tick;
        hold_seen    = 0;
        hold_left    = 0;
        tick         = 0;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_seq)
            begin
                hold_seen = hold_seq;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                tick++;
                case ((tick / 300) % 3)
                    0: result_ready <= 1'b1;
                    1: result_ready <= ($urandom_range(0, 3) != 0);
                    default: result_ready <= ((tick % 8) < 3);
                endcase
            end
        end
    end

    task automatic test_empty_batches();
        int unsigned seq [$];
        seq = {15};
        send_batch(seq);
        seq = {10};
        send_batch(seq);
    endtask

    task automatic test_single_extremes();
        int unsigned seq [$];
        seq = {0};
        send_batch(seq);
        seq = {9};
        send_batch(seq);
    endtask

    task automatic test_median_rules();
        int unsigned seq [$];
        seq = {2, 7};
        send_batch(seq);
        seq = {1, 2, 3};
        send_batch(seq);
    endtask

    task automatic test_ties_and_modes();
        int unsigned seq [$];
        seq = {3, 3, 5, 5};
        send_batch(seq);
        seq = {0, 0, 4};
        send_batch(seq);
    endtask

    task automatic test_ignored_values();
        int unsigned seq [$];
        seq = {4, 12, 6, 11};
        send_batch(seq);
    endtask

    // The result register stays full during a long hold, so the block must stall its input.
    task automatic test_backpressure();
        int unsigned seq [$];
        gaps_enabled = 1'b0;
        hold_seq++;
        for (int k = 0; k < 4; k++)
        begin
            seq.delete();
            repeat (12)
                seq.push_back($urandom_range(0, 9));
            send_batch(seq);
        end
        gaps_enabled = 1'b1;
    endtask

    task automatic test_random_batches(input int target);
        int unsigned seq [$];
        int unsigned favored [3];
        int          in_range;
        int          len;
        int unsigned v;
        in_range = 0;
        while (in_range < target)
        begin
            len = ($urandom_range(0, 29) == 0) ? $urandom_range(125, 160)
                                                : $urandom_range(1, 16);
            foreach (favored[f])
                favored[f] = $urandom_range(0, 9);
            seq.delete();
            repeat (len)
            begin
                case ($urandom_range(0, 15))
                    0:       v = $urandom_range(10, 15);
                    1, 2, 3: v = $urandom_range(0, 9);
                    default: v = favored[$urandom_range(0, 2)];
                endcase
                if (v < NUM_BINS)
                    in_range++;
                seq.push_back(v);
            end
            send_batch(seq);
        end
    endtask

    task automatic finish_run();
        int waited;
        waited = 0;
        item_valid <= 1'b0;
        while (pending_stats.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_stats.size() != 0)
        begin
            mismatches++;
            $display("%0t: results outstanding expected 0 actual %0d", $time,
                     pending_stats.size());
        end
        repeat (NUM_BINS + 4) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        mismatches   = 0;
        burst_left   = 0;
        gaps_enabled = 1'b1;
        hold_seq     = 0;
        clear_histogram();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_batches();
        test_single_extremes();
        test_median_rules();
        test_ties_and_modes();
        test_ignored_values();
        test_backpressure();
        test_random_batches(RANDOM_ITEMS);
        finish_run();
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/histmmm_pkg.sv
rtl/core/histogram_mean_median_mode.sv
dv/histogram_mean_median_mode_tb.sv
